### hw/rtl/pfa_pkg.sv
// Shared types, codes and defaults of the page frame allocator.
package pfa_pkg;

	localparam int FIELD_W  = 48;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 3;

	localparam int PFA_NUM_REGIONS = 16;
	localparam int PFA_PAGE_SHIFT  = 12;
	localparam int PFA_FREED_DEPTH = 64;
	localparam int PFA_ADDR_BITS   = 48;

	localparam logic [FIELD_W-1:0] SENTINEL_RESET = '1;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_FREE   = 2'd3
	} pfa_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 3'd0,
		STAT_NO_FRAME   = 3'd1,
		STAT_EMPTY_ADD  = 3'd2,
		STAT_BAD_SLOT   = 3'd3,
		STAT_SENTINEL   = 3'd4,
		STAT_STACK_FULL = 3'd5,
		STAT_SPLIT_LOST = 3'd6
	} pfa_status_t;

	typedef struct packed {
		pfa_op_t             operation;
		logic [FIELD_W-1:0]  region_addr;
		logic [FIELD_W-1:0]  region_length;
		logic [SLOT_W-1:0]   slot_index;
		logic [FIELD_W-1:0]  cut_start;
		logic [FIELD_W-1:0]  cut_end;
		logic [FIELD_W-1:0]  returned_frame;
	} pfa_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] frame_addr;
		pfa_status_t        status;
	} pfa_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_START,
		ST_ADD_END,
		ST_ADD_CHECK,
		ST_CUT_ROUND,
		ST_CUT_CHECK,
		ST_CUT_SCAN,
		ST_CUT_EVAL,
		ST_CUT_FREE,
		ST_ALLOC_POP,
		ST_ALLOC_POPW,
		ST_ALLOC_SCAN,
		ST_ALLOC_TAKE,
		ST_FREE_PUSH,
		ST_RESP
	} pfa_state_t;

endpackage

### hw/rtl/pfa_ram.sv
// Generic single write port RAM with registered read.
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/page_frame_allocator_core.sv
// Page frame allocator: region table, freed frame stack and sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_stall   | in_item  (pfa_in_t)
//  out     | output    | out_valid / out_stall | out_item (pfa_out_t)
//  cfg     | input     | cfg_wr_en             | cfg_wr_data (sentinel)
//
// One item at a time. Add passes through its start, end and check states; free pushes
// onto the stack; alloc pops the stack, or scans the table (up to NUM_REGIONS slots)
// when the stack is empty. Remove rounds the cut and returns without a scan for an empty
// cut, else evaluates each valid slot and, per split, searches up to NUM_REGIONS slots
// for a free one; the single table read port and the one shared adder set these steps.
// Reset clears the region valid marks and the stack count; the sentinel goes to all ones.
// A result waits in the output register; the next item is taken meanwhile, and
// a later result stays in its response state while an earlier one is held by out_stall.
module page_frame_allocator_core
	import pfa_pkg::*;
#(
	parameter int NUM_REGIONS = PFA_NUM_REGIONS,
	parameter int PAGE_SHIFT  = PFA_PAGE_SHIFT,
	parameter int FREED_DEPTH = PFA_FREED_DEPTH,
	parameter int ADDR_BITS   = PFA_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pfa_in_t            in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output pfa_out_t           out_item,
	input  logic               cfg_wr_en,
	input  logic [FIELD_W-1:0] cfg_wr_data
);

	localparam int AW  = ADDR_BITS;
	localparam int PS  = PAGE_SHIFT;
	localparam int PW  = AW - PS;
	localparam int RIW = $clog2(NUM_REGIONS);
	localparam int RCW = $clog2(NUM_REGIONS + 1);
	localparam int SIW = (FREED_DEPTH > 1) ? $clog2(FREED_DEPTH) : 1;
	localparam int CNW = $clog2(FREED_DEPTH + 1);
	localparam int CW  = (AW > FIELD_W) ? AW : FIELD_W;

	localparam logic [AW-1:0]     PMASK     = {{PW{1'b0}}, {PS{1'b1}}};
	localparam logic [RCW-1:0]    NREG      = RCW'(NUM_REGIONS);
	localparam logic [SLOT_W:0]   NREG_SLOT = (SLOT_W + 1)'(NUM_REGIONS);
	localparam logic [CNW-1:0]    NFREED    = CNW'(FREED_DEPTH);

	pfa_state_t state_q, state_d;

	logic                   accept;
	logic [FIELD_W-1:0]     sentinel_q;
	logic [NUM_REGIONS-1:0] vld_q;
	logic [CNW-1:0]         count_q;
	logic [CNW-1:0]         cnt_m1;
	logic                   out_valid_q;
	pfa_out_t               out_item_q;

	logic [AW-1:0]   a_q, b_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PW-1:0]   s_pg_q, e_pg_q, re_q;
	logic            flag_q;
	logic [RCW-1:0]  idx_q, jdx_q;
	pfa_status_t     stat_q;
	logic [FIELD_W-1:0] frame_q;

	// shared adder
	logic [AW-1:0] alu_a, alu_b;
	logic [AW:0]   alu_sum;
	logic          alu_carry;
	logic [PW-1:0] alu_pg;

	// region table
	logic             reg_we;
	logic [RIW-1:0]   reg_waddr;
	logic [2*PW-1:0]  reg_wdata, reg_rdata;
	logic [PW-1:0]    rd_base, rd_end;

	// freed stack
	logic           stk_we;
	logic [AW-1:0]  stk_rdata;

	logic           vld_set, vld_clr;
	logic [RIW-1:0] vld_idx;
	logic           cnt_inc, cnt_dec;
	logic           out_load;

	logic scan_end, jdx_end, vld_at_idx, vld_at_jdx;
	logic add_empty, slot_bad, take_last;
	logic e_le_rs, s_ge_re, s_le_rs, e_ge_re;
	logic cut_none, cut_all, cut_split;
	logic free_match, stack_full;

	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b};
	assign alu_carry = alu_sum[AW];
	assign alu_pg    = alu_sum[AW-1:PS];

	assign rd_base = reg_rdata[2*PW-1:PW];
	assign rd_end  = reg_rdata[PW-1:0];
	assign cnt_m1  = count_q - CNW'(1);

	assign scan_end   = (idx_q == NREG);
	assign jdx_end    = (jdx_q == NREG);
	assign vld_at_idx = vld_q[idx_q[RIW-1:0]];
	assign vld_at_jdx = vld_q[jdx_q[RIW-1:0]];

	assign add_empty = flag_q || (e_pg_q <= s_pg_q);
	assign slot_bad  = ({1'b0, slot_q} >= NREG_SLOT);
	assign take_last = (alu_sum[PW-1:0] >= rd_end);

	assign e_le_rs   = (e_pg_q <= rd_base);
	assign s_ge_re   = (s_pg_q >= rd_end);
	assign s_le_rs   = (s_pg_q <= rd_base);
	assign e_ge_re   = (e_pg_q >= rd_end);
	assign cut_none  = e_le_rs || s_ge_re;
	assign cut_all   = s_le_rs && e_ge_re;
	assign cut_split = !cut_none && !s_le_rs && !e_ge_re;

	assign free_match = (CW'(a_q) == CW'(sentinel_q));
	assign stack_full = (count_q >= NFREED);

	pfa_ram #(
		.WIDTH(2 * PW),
		.DEPTH(NUM_REGIONS)
	) u_region_ram (
		.clk  (clk),
		.we   (reg_we),
		.waddr(reg_waddr),
		.wdata(reg_wdata),
		.raddr(idx_q[RIW-1:0]),
		.rdata(reg_rdata)
	);

	pfa_ram #(
		.WIDTH(AW),
		.DEPTH(FREED_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(count_q[SIW-1:0]),
		.wdata(a_q),
		.raddr(cnt_m1[SIW-1:0]),
		.rdata(stk_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_item.operation)
						OP_ADD:    state_d = ST_ADD_START;
						OP_REMOVE: state_d = ST_CUT_ROUND;
						OP_ALLOC:  state_d = ST_ALLOC_POP;
						OP_FREE:   state_d = ST_FREE_PUSH;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_START: state_d = ST_ADD_END;
			ST_ADD_END:   state_d = ST_ADD_CHECK;
			ST_ADD_CHECK: state_d = ST_RESP;
			ST_CUT_ROUND: state_d = ST_CUT_CHECK;
			ST_CUT_CHECK: begin
				state_d = (e_pg_q <= s_pg_q) ? ST_RESP : ST_CUT_SCAN;
			end
			ST_CUT_SCAN: begin
				if (scan_end) begin
					state_d = ST_RESP;
				end else if (vld_at_idx) begin
					state_d = ST_CUT_EVAL;
				end
			end
			ST_CUT_EVAL: state_d = cut_split ? ST_CUT_FREE : ST_CUT_SCAN;
			ST_CUT_FREE: begin
				if (jdx_end || !vld_at_jdx) begin
					state_d = ST_CUT_SCAN;
				end
			end
			ST_ALLOC_POP: begin
				state_d = (count_q == '0) ? ST_ALLOC_SCAN : ST_ALLOC_POPW;
			end
			ST_ALLOC_POPW: state_d = ST_RESP;
			ST_ALLOC_SCAN: begin
				if (scan_end) begin
					state_d = ST_RESP;
				end else if (vld_at_idx) begin
					state_d = ST_ALLOC_TAKE;
				end
			end
			ST_ALLOC_TAKE: state_d = ST_RESP;
			ST_FREE_PUSH:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_load  = 1'b0;
		alu_a     = a_q;
		alu_b     = PMASK;
		reg_we    = 1'b0;
		reg_waddr = idx_q[RIW-1:0];
		reg_wdata = {rd_base, s_pg_q};
		vld_set   = 1'b0;
		vld_clr   = 1'b0;
		vld_idx   = idx_q[RIW-1:0];
		stk_we    = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		case (state_q)
			ST_ADD_END: begin
				alu_b = b_q;
			end
			ST_ADD_CHECK: begin
				if (!add_empty && !slot_bad) begin
					reg_we    = 1'b1;
					reg_waddr = slot_q[RIW-1:0];
					reg_wdata = {s_pg_q, e_pg_q};
					vld_set   = 1'b1;
					vld_idx   = slot_q[RIW-1:0];
				end
			end
			ST_CUT_EVAL: begin
				if (!cut_none) begin
					if (cut_all) begin
						vld_clr = 1'b1;
					end else if (s_le_rs) begin
						reg_we    = 1'b1;
						reg_wdata = {e_pg_q, rd_end};
					end else begin
						reg_we = 1'b1;
					end
				end
			end
			ST_CUT_FREE: begin
				if (!jdx_end && !vld_at_jdx) begin
					reg_we    = 1'b1;
					reg_waddr = jdx_q[RIW-1:0];
					reg_wdata = {e_pg_q, re_q};
					vld_set   = 1'b1;
					vld_idx   = jdx_q[RIW-1:0];
				end
			end
			ST_ALLOC_POP: begin
				cnt_dec = (count_q != '0);
			end
			ST_ALLOC_TAKE: begin
				alu_a = AW'(rd_base);
				alu_b = AW'(1);
				if (take_last) begin
					vld_clr = 1'b1;
				end else begin
					reg_we    = 1'b1;
					reg_wdata = {alu_sum[PW-1:0], rd_end};
				end
			end
			ST_FREE_PUSH: begin
				if (!free_match && !stack_full) begin
					stk_we  = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ST_RESP: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sentinel_q  <= SENTINEL_RESET;
			vld_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				sentinel_q <= cfg_wr_data;
			end
			if (vld_set) begin
				vld_q[vld_idx] <= 1'b1;
			end
			if (vld_clr) begin
				vld_q[vld_idx] <= 1'b0;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNW'(1);
			end else if (cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q  <= in_item.slot_index;
			idx_q   <= '0;
			stat_q  <= STAT_OK;
			frame_q <= '0;
			case (in_item.operation)
				OP_ADD: begin
					a_q <= AW'(in_item.region_addr);
					b_q <= AW'(in_item.region_length);
				end
				OP_REMOVE: begin
					a_q <= AW'(in_item.cut_end);
					b_q <= AW'(in_item.cut_start);
				end
				default: begin
					a_q <= AW'(in_item.returned_frame);
					b_q <= '0;
				end
			endcase
		end
		case (state_q)
			ST_ADD_START: begin
				s_pg_q <= alu_pg;
				flag_q <= alu_carry;
			end
			ST_ADD_END: begin
				e_pg_q <= alu_carry ? '1 : alu_pg;
			end
			ST_ADD_CHECK: begin
				if (add_empty) begin
					stat_q <= STAT_EMPTY_ADD;
				end else if (slot_bad) begin
					stat_q <= STAT_BAD_SLOT;
				end
			end
			ST_CUT_ROUND: begin
				s_pg_q <= b_q[AW-1:PS];
				e_pg_q <= alu_carry ? '1 : alu_pg;
			end
			ST_CUT_SCAN: begin
				if (!scan_end && !vld_at_idx) begin
					idx_q <= idx_q + RCW'(1);
				end
			end
			ST_CUT_EVAL: begin
				if (cut_split) begin
					re_q  <= rd_end;
					jdx_q <= '0;
				end else begin
					idx_q <= idx_q + RCW'(1);
				end
			end
			ST_CUT_FREE: begin
				if (jdx_end) begin
					stat_q <= STAT_SPLIT_LOST;
					idx_q  <= idx_q + RCW'(1);
				end else if (!vld_at_jdx) begin
					idx_q <= idx_q + RCW'(1);
				end else begin
					jdx_q <= jdx_q + RCW'(1);
				end
			end
			ST_ALLOC_POPW: begin
				frame_q <= FIELD_W'(stk_rdata);
			end
			ST_ALLOC_SCAN: begin
				if (scan_end) begin
					frame_q <= sentinel_q;
					stat_q  <= STAT_NO_FRAME;
				end else if (!vld_at_idx) begin
					idx_q <= idx_q + RCW'(1);
				end
			end
			ST_ALLOC_TAKE: begin
				frame_q <= FIELD_W'({rd_base, {PS{1'b0}}});
			end
			ST_FREE_PUSH: begin
				if (free_match) begin
					stat_q <= STAT_SENTINEL;
				end else if (stack_full) begin
					stat_q <= STAT_STACK_FULL;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_item_q.frame_addr <= frame_q;
			out_item_q.status     <= stat_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !out_load)
		else $error("waiting result overwritten");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("item taken while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NFREED)
		else $error("freed stack count past depth");

	a_count_steady: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_ALLOC_POP || state_q == ST_FREE_PUSH) |=> $stable(count_q))
		else $error("freed stack count moved outside pop or push");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CUT_SCAN || state_q == ST_ALLOC_SCAN) |-> idx_q <= NREG)
		else $error("table scan past last slot");
`endif

endmodule
